>>> rtl/fufl_pkg.sv
// ----------------------------------------------------------------------------
// fufl_pkg
// Types and codes shared by the fixed-unit free-list allocator files.
// ----------------------------------------------------------------------------
package fufl_pkg;

   localparam int TYPE_W  = 2;
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;
   localparam int GRANT_W = 10;
   localparam int STAT_W  = 2;

   // request kinds
   localparam logic [TYPE_W-1:0] REQ_ALLOC  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_FREE   = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_ATTACH = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

   // result status codes
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [TYPE_W-1:0]  req_type;
      logic [INDEX_W-1:0] unit_index;
      logic [COUNT_W-1:0] unit_count;
   } req_beat_type;

   typedef struct packed {
      logic [GRANT_W-1:0] granted_unit;
      logic [STAT_W-1:0]  status;
   } rsp_beat_type;

endpackage

>>> rtl/fixed_unit_free_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// fixed_unit_free_list_allocator_unit
// LIFO free list of equal-size units held in a link memory plus a head
// register.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat is taken on a clock edge with start high and busy low.
//   Kinds: allocate pops the head unit, free pushes one unit, attach links
//   a run of consecutive units in front of the current list.
//   Every request yields exactly one result beat, shown on rsp_data for one
//   cycle with rsp_valid high; the receiver has no way to stall it.
// Sequencing:
//   free, unused kind, empty allocate, rejected or empty attach: no extra state
//   allocate with a unit available: one link memory read (S_ALLOC)
//   attach of N units: one link write per unit (S_WALK)
//   busy is low again in the cycle the result shows, so back-to-back free
//   requests run at one per cycle; an allocate is busy through its read.
// Reset: the head goes to the null value (list empty); the link memory is
//   not cleared, since no entry is read before it is linked.
// ----------------------------------------------------------------------------
module fixed_unit_free_list_allocator_unit #(
   parameter int NUM_UNITS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  fufl_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   output fufl_pkg::rsp_beat_type rsp_data
);

   localparam int AW = $clog2(NUM_UNITS);
   localparam int LW = $clog2(NUM_UNITS + 1);
   localparam logic [LW-1:0] NULL_LINK = LW'(NUM_UNITS);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ALLOC,
      S_WALK
   } state_type;

   state_type              state_ff, state_in;
   logic [LW-1:0]          head_ff, head_in;
   logic [LW-1:0]          first_ff, first_in;
   logic [AW-1:0]          ptr_ff, ptr_in;
   logic [fufl_pkg::COUNT_W-1:0] left_ff, left_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   fufl_pkg::rsp_beat_type rsp_ff, rsp_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [LW-1:0]          wr_data;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [LW-1:0]          rd_data;

   logic [31:0]            idx32;
   logic [31:0]            cnt32;
   logic [31:0]            head32;
   logic [31:0]            link32;

   assign idx32  = 32'(req_data.unit_index);
   assign cnt32  = 32'(req_data.unit_count);
   assign head32 = 32'(head_ff);
   assign link32 = 32'(rd_data);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      first_in     = first_ff;
      ptr_in       = ptr_ff;
      left_in      = left_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = head_ff;
      rd_en        = 1'b0;
      rd_addr      = head32[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_data.req_type)
                  fufl_pkg::REQ_ALLOC: begin
                     if (head32 < NUM_UNITS) begin
                        rd_en    = 1'b1;
                        state_in = S_ALLOC;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = fufl_pkg::ST_EMPTY;
                     end
                  end
                  fufl_pkg::REQ_FREE: begin
                     rsp_valid_in = 1'b1;
                     // out-of-pool index is dropped silently
                     if (idx32 < NUM_UNITS) begin
                        wr_en   = 1'b1;
                        wr_addr = idx32[AW-1:0];
                        wr_data = head_ff;
                        head_in = idx32[LW-1:0];
                     end
                  end
                  fufl_pkg::REQ_ATTACH: begin
                     if (cnt32 == 32'd0) begin
                        rsp_valid_in = 1'b1;
                     end else if (idx32 + cnt32 > NUM_UNITS) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = fufl_pkg::ST_RANGE;
                     end else begin
                        ptr_in   = idx32[AW-1:0];
                        first_in = idx32[LW-1:0];
                        left_in  = req_data.unit_count;
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_ALLOC: begin
            rsp_valid_in        = 1'b1;
            rsp_in.granted_unit = head32[fufl_pkg::GRANT_W-1:0];
            head_in             = (link32 < NUM_UNITS) ? rd_data : NULL_LINK;
            state_in            = S_IDLE;
         end
         S_WALK: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            if (left_ff == fufl_pkg::COUNT_W'(1)) begin
               // last unit of the run points at the old list
               wr_data      = head_ff;
               head_in      = first_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               wr_data = LW'(32'(ptr_ff) + 32'd1);
               ptr_in  = ptr_ff + AW'(1);
               left_in = left_ff - fufl_pkg::COUNT_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      ptr_ff   <= ptr_in;
      left_ff  <= left_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NULL_LINK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   fufl_link_ram #(
      .DEPTH (NUM_UNITS),
      .DW    (LW)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/fufl_link_ram.sv
// ----------------------------------------------------------------------------
// fufl_link_ram
// Link memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fufl_link_ram #(
   parameter int DEPTH = 1024,
   parameter int DW    = 11
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DW-1:0]            wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DW-1:0]            rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/fufl_checker.sv
// ----------------------------------------------------------------------------
// fufl_checker
// Port-level checks for the free-list allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fufl_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input fufl_pkg::req_beat_type req_data,
   input logic                   rsp_valid,
   input fufl_pkg::rsp_beat_type rsp_data
);

   // a result beat only follows an accepted or in-flight request
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("result beat without a request");

   // a result with a failing status carries a zero granted unit
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != fufl_pkg::ST_OK) |-> rsp_data.granted_unit == '0)
      else $error("granted unit nonzero on failing result");

   // free shows its result in the cycle after it is accepted and leaves the block ready
   a_free_single: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.req_type == fufl_pkg::REQ_FREE) |=> (rsp_valid && !busy))
      else $error("free did not finish in one cycle");

   // allocate either reads the link memory or reports empty at once
   a_alloc_path: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.req_type == fufl_pkg::REQ_ALLOC)
         |=> (busy || (rsp_valid && rsp_data.status == fufl_pkg::ST_EMPTY)))
      else $error("allocate took an unexpected path");

endmodule

bind fixed_unit_free_list_allocator_unit fufl_checker u_fufl_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

>>> sim/fixed_unit_free_list_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// fixed_unit_free_list_allocator_unit_tb
// Self-checking bench for the fixed-unit free-list allocator. Each request
// beat is applied to an in-bench copy of the free list and link memory. Each
// result beat is checked against the oldest predicted result. Stimulus is a
// directed opening (empty pool, range errors, full-pool attach, double free,
// unused kind) and then random allocate/free/attach/unused traffic with random gaps.
// ----------------------------------------------------------------------------
module fixed_unit_free_list_allocator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_UNITS = 1024;
   localparam int LINK_W    = $clog2(NUM_UNITS) + 1;
   localparam int N_RANDOM  = 1000;

   // -------------------------------------------------------------------------
   // Free-list shadow and result checker
   // -------------------------------------------------------------------------
   class free_list_checker;
      logic [LINK_W-1:0]      link_mem [NUM_UNITS];
      logic [LINK_W-1:0]      head;
      fufl_pkg::rsp_beat_type awaited_results [$];
      int                     handed_out [$];   // units granted and not yet freed
      int                     error_count;

      function new();
         head        = LINK_W'(NUM_UNITS);
         error_count = 0;
      endfunction

      function void note_request(input fufl_pkg::req_beat_type beat);
         fufl_pkg::rsp_beat_type rsp;
         logic [LINK_W-1:0]      nxt;
         int                     first;
         int                     cnt;
         rsp.granted_unit = '0;
         rsp.status       = fufl_pkg::ST_OK;
         first            = int'(beat.unit_index);
         cnt              = int'(beat.unit_count);
         case (beat.req_type)
            fufl_pkg::REQ_ALLOC: begin
               if (head >= NUM_UNITS) begin
                  head       = LINK_W'(NUM_UNITS);
                  rsp.status = fufl_pkg::ST_EMPTY;
               end else begin
                  rsp.granted_unit = head[fufl_pkg::GRANT_W-1:0];
                  handed_out.push_back(int'(head));
                  nxt  = link_mem[head];
                  head = (nxt >= NUM_UNITS) ? LINK_W'(NUM_UNITS) : nxt;
               end
            end
            fufl_pkg::REQ_FREE: begin
               if (first < NUM_UNITS) begin
                  link_mem[first] = head;
                  head            = LINK_W'(first);
               end
            end
            fufl_pkg::REQ_ATTACH: begin
               if (cnt == 0) begin
                  rsp.status = fufl_pkg::ST_OK;
               end else if (first + cnt > NUM_UNITS) begin
                  rsp.status = fufl_pkg::ST_RANGE;
               end else begin
                  for (int k = 0; k + 1 < cnt; k++)
                     link_mem[first + k] = LINK_W'(first + k + 1);
                  link_mem[first + cnt - 1] = head;
                  head = LINK_W'(first);
               end
            end
            default: ;
         endcase
         awaited_results.push_back(rsp);
      endfunction

      function void check_result(input fufl_pkg::rsp_beat_type got);
         fufl_pkg::rsp_beat_type want;
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result beat grant=%0d status=%0d",
                     $time, got.granted_unit, got.status);
            error_count++;
            return;
         end
         want = awaited_results.pop_front();
         if (got.granted_unit !== want.granted_unit) begin
            $display("%0t: granted_unit mismatch expected=%0d actual=%0d",
                     $time, want.granted_unit, got.granted_unit);
            error_count++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status mismatch expected=%0d actual=%0d",
                     $time, want.status, got.status);
            error_count++;
         end
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT and clock
   // -------------------------------------------------------------------------
   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   fufl_pkg::req_beat_type req_data;
   logic                   rsp_valid;
   fufl_pkg::rsp_beat_type rsp_data;

   free_list_checker checker_h;

   fixed_unit_free_list_allocator_unit #(
      .NUM_UNITS(NUM_UNITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         checker_h.check_result(rsp_data);
   end

   // -------------------------------------------------------------------------
   // Drivers; entered and left at a falling edge
   // -------------------------------------------------------------------------
   task automatic send_request(input fufl_pkg::req_beat_type beat, input int gap);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    = 1'b1;
      req_data = beat;
      do @(posedge clock); while (busy);
      checker_h.note_request(beat);
      @(negedge clock);
   endtask

   task automatic send_fields(input logic [fufl_pkg::TYPE_W-1:0] kind, input int idx,
                              input int cnt);
      fufl_pkg::req_beat_type beat;
      beat.req_type   = kind;
      beat.unit_index = fufl_pkg::INDEX_W'(idx);
      beat.unit_count = fufl_pkg::COUNT_W'(cnt);
      send_request(beat, $urandom_range(0, 6));
   endtask

   function automatic fufl_pkg::req_beat_type random_request();
      fufl_pkg::req_beat_type beat;
      int                     pick;
      int                     sub;
      int                     cnt;
      int                     pos;
      beat.unit_index = fufl_pkg::INDEX_W'($urandom);
      beat.unit_count = fufl_pkg::COUNT_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         beat.req_type = fufl_pkg::REQ_ALLOC;
      end else if (pick < 70) begin
         beat.req_type = fufl_pkg::REQ_FREE;
         // mostly give back a unit that was actually handed out
         if (checker_h.handed_out.size() > 0 && $urandom_range(0, 3) != 0) begin
            pos = $urandom_range(0, checker_h.handed_out.size() - 1);
            beat.unit_index = fufl_pkg::INDEX_W'(checker_h.handed_out[pos]);
            checker_h.handed_out.delete(pos);
         end
      end else if (pick < 95) begin
         beat.req_type = fufl_pkg::REQ_ATTACH;
         sub = $urandom_range(0, 19);
         if (sub == 0) begin
            beat.unit_count = fufl_pkg::COUNT_W'($urandom_range(0, 2047));
         end else if (sub == 1) begin
            cnt = $urandom_range(256, NUM_UNITS);
            beat.unit_count = fufl_pkg::COUNT_W'(cnt);
            beat.unit_index = fufl_pkg::INDEX_W'($urandom_range(0, NUM_UNITS - cnt));
         end else if (sub < 5) begin
            // runs near the end of the pool, some past it
            pos = $urandom_range(NUM_UNITS - 24, NUM_UNITS - 1);
            beat.unit_index = fufl_pkg::INDEX_W'(pos);
            beat.unit_count = fufl_pkg::COUNT_W'($urandom_range(0, 30));
         end else begin
            cnt = $urandom_range(1, 8);
            beat.unit_count = fufl_pkg::COUNT_W'(cnt);
            beat.unit_index = fufl_pkg::INDEX_W'($urandom_range(0, NUM_UNITS - cnt));
         end
      end else begin
         beat.req_type = fufl_pkg::REQ_UNUSED;
      end
      return beat;
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int gap;
      checker_h = new();
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed opening
      send_fields(fufl_pkg::REQ_ALLOC, 0, 0);                 // empty pool
      send_fields(fufl_pkg::REQ_UNUSED, NUM_UNITS - 1, 2047); // unused kind
      send_fields(fufl_pkg::REQ_ATTACH, 0, 0);                // zero-unit attach
      send_fields(fufl_pkg::REQ_ATTACH, NUM_UNITS - 1, 2);    // one past the end
      send_fields(fufl_pkg::REQ_ATTACH, 1, NUM_UNITS);
      send_fields(fufl_pkg::REQ_ATTACH, 0, 2047);
      send_fields(fufl_pkg::REQ_FREE, NUM_UNITS - 1, 2047);
      send_fields(fufl_pkg::REQ_ALLOC, NUM_UNITS - 1, 2047);
      send_fields(fufl_pkg::REQ_ALLOC, 0, 0);
      send_fields(fufl_pkg::REQ_ATTACH, NUM_UNITS - 1, 1);    // last unit only
      send_fields(fufl_pkg::REQ_ATTACH, 0, NUM_UNITS);        // whole pool
      send_fields(fufl_pkg::REQ_ALLOC, 0, 0);
      send_fields(fufl_pkg::REQ_ALLOC, 0, 0);
      send_fields(fufl_pkg::REQ_FREE, 0, 0);
      send_fields(fufl_pkg::REQ_FREE, 0, 0);                  // double free, self loop
      send_fields(fufl_pkg::REQ_ALLOC, 0, 0);
      send_fields(fufl_pkg::REQ_ALLOC, 0, 0);
      send_fields(fufl_pkg::REQ_ATTACH, 5, 3);
      send_fields(fufl_pkg::REQ_FREE, 512, 1024);
      send_fields(fufl_pkg::REQ_ALLOC, 0, 0);
      send_fields(fufl_pkg::REQ_ALLOC, 0, 0);
      send_fields(fufl_pkg::REQ_ALLOC, 0, 0);
      send_fields(fufl_pkg::REQ_ALLOC, 0, 0);
      checker_h.handed_out.delete();

      for (int n = 0; n < N_RANDOM; n++) begin
         // stretches of back-to-back beats between idle stretches
         gap = (n % 100 < 30) ? 0 : $urandom_range(0, 6);
         send_request(random_request(), gap);
      end
      start = 1'b0;

      while (checker_h.pending() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (checker_h.error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #100_000_000;
      $display("%0t: timeout", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> fixed_unit_free_list_allocator_unit.f
rtl/fufl_pkg.sv
rtl/fufl_link_ram.sv
rtl/fixed_unit_free_list_allocator_unit.sv
rtl/fufl_checker.sv
sim/fixed_unit_free_list_allocator_unit_tb.sv
